### sv/csd_pkg.sv
package csd_pkg;

  localparam logic [7:0] PFX_U16 = 8'hfd;
  localparam logic [7:0] PFX_U32 = 8'hfe;
  localparam logic [7:0] PFX_U64 = 8'hff;

  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Queue entry: zero, one or two results caused by one input item.
  // The second result is always the too-short error.
  typedef struct packed {
    logic        first_en;
    logic [1:0]  first_kind;
    logic [63:0] first_value;
    logic        err_en;
  } csd_entry_t;

endpackage

### sv/csd_front.sv
module csd_front import csd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push_valid,
  input  logic       push_ready,
  output csd_entry_t push_entry
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PREFIX  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] pbl_r, pbl_nxt;
  logic        mode_r;

  logic        fin;
  logic [63:0] fin_v;
  logic [63:0] acc_or;
  logic [3:0]  left_dec;
  logic [63:0] pbl_dec;
  csd_entry_t  ent;
  logic        accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    pbl_nxt   = pbl_r;
    fin       = 1'b0;
    fin_v     = '0;
    ent       = '0;
    acc_or    = acc_r | ({56'd0, in_byte} << {pos_r, 3'b000});
    left_dec  = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;
    pbl_dec   = (pbl_r != 64'd0) ? pbl_r - 64'd1 : 64'd0;

    unique case (phase_r)
      PH_PREFIX: begin
        acc_nxt  = acc_or;
        pos_nxt  = pos_r + 3'd1;
        left_nxt = left_dec;
        if (left_dec == 4'd0) begin
          fin   = 1'b1;
          fin_v = acc_or;
        end
      end
      PH_PAYLOAD: begin
        ent.first_en    = 1'b1;
        ent.first_kind  = KIND_PAYLOAD;
        ent.first_value = {56'd0, in_byte};
        pbl_nxt         = pbl_dec;
        if (pbl_dec == 64'd0) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (in_byte < PFX_U16) begin
          fin   = 1'b1;
          fin_v = {56'd0, in_byte};
        end else begin
          phase_nxt = PH_PREFIX;
          pos_nxt   = 3'd0;
          acc_nxt   = '0;
          left_nxt  = (in_byte == PFX_U16) ? 4'd2 :
                      (in_byte == PFX_U32) ? 4'd4 : 4'd8;
        end
      end
    endcase

    // value complete: emit it, open a payload in string mode if it is nonzero
    if (fin) begin
      ent.first_en    = 1'b1;
      ent.first_kind  = KIND_VALUE;
      ent.first_value = fin_v;
      if (mode_r && (fin_v != 64'd0)) begin
        phase_nxt = PH_PAYLOAD;
        pbl_nxt   = fin_v;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end

    // buffer ends: flag a truncated prefix or payload
    if (in_last) begin
      if ((phase_nxt == PH_PREFIX) || (phase_nxt == PH_PAYLOAD)) begin
        ent.err_en = 1'b1;
      end
      phase_nxt = PH_IDLE;
    end
  end

  assign push_valid = accept && (ent.first_en || ent.err_en);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= '0;
      pos_r   <= '0;
      acc_r   <= '0;
      pbl_r   <= '0;
      mode_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_mode;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
        pos_r   <= pos_nxt;
        acc_r   <= acc_nxt;
        pbl_r   <= pbl_nxt;
      end
    end
  end

endmodule

### sv/csd_fifo.sv
module csd_fifo import csd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  csd_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output csd_entry_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csd_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

### sv/csd_back.sv
module csd_back import csd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  csd_entry_t  pop_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [63:0] out_value,
  output logic        out_last
);

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [63:0] value_r;
  logic        last_r;
  logic        err_pend_r;
  logic        take;

  // output register free or draining this cycle
  assign take      = !valid_r || out_ready;
  assign pop_ready = take && !err_pend_r;

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      err_pend_r <= 1'b0;
      kind_r     <= KIND_VALUE;
      value_r    <= '0;
      last_r     <= 1'b0;
    end else if (take) begin
      if (err_pend_r) begin
        valid_r    <= 1'b1;
        kind_r     <= KIND_ERROR;
        value_r    <= '0;
        last_r     <= 1'b1;
        err_pend_r <= 1'b0;
      end else if (pop_valid) begin
        valid_r <= 1'b1;
        if (pop_entry.first_en) begin
          kind_r     <= pop_entry.first_kind;
          value_r    <= pop_entry.first_value;
          last_r     <= !pop_entry.err_en;
          err_pend_r <= pop_entry.err_en;
        end else begin
          kind_r  <= KIND_ERROR;
          value_r <= '0;
          last_r  <= 1'b1;
        end
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

### sv/compactsize_stream_decoder.sv
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | tdata[7:0] byte, tlast end of buffer
// out_    | out | out_tvalid / out_tready| tdata[63:0] value, tuser kind, tlast
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_data string mode (always ready)
//
// One input item per cycle while the queue has room. Items giving one result
// or none keep that rate; an item that also ends a buffer early gives two
// results, which the output register issues in turn, the queue absorbing
// the extra one. Each result is queued at the edge that accepts its item
// and is then loaded from the queue into the output register.
// rst_n is synchronous, active low; no clearing pass is needed.
// in_tready drops only when the queue between parser and output is full.
module compactsize_stream_decoder import csd_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [63:0] res_value
  output logic [1:0]  out_tuser,   // [1:0] res_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  csd_entry_t push_entry, pop_entry;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  // front: parses bytes, classifies each item into a queue entry
  csd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_mode   (cfg_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  csd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // back: expands entries into one or two result items
  csd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_value (out_tdata),
    .out_last  (out_tlast)
  );

`ifndef SYNTHESIS
  // a too-short error is always the final result of its item and carries zero
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ERROR) |-> out_tlast && (out_tdata == 64'd0))
    else $error("error result not last or nonzero");

  // payload results carry one byte
  a_payload_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_PAYLOAD) |-> (out_tdata[63:8] == 56'd0))
    else $error("payload result wider than a byte");

  // a non-final result is followed at once by its pending error
  a_err_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && (out_tuser == KIND_ERROR))
    else $error("pending error not issued");
`endif

endmodule
